// File: rtl/xcfr_pkg.sv
package xcfr_pkg;

  // Frame layout
  localparam int unsigned StoreDepth = 12;
  localparam int unsigned CountW     = 8;
  localparam int unsigned StoreIdxW  = $clog2(StoreDepth);

  localparam logic [7:0] HeaderReset = 8'hAA;

  // Result status codes
  localparam logic [1:0] StatusValues   = 2'd0;
  localparam logic [1:0] StatusOtherLen = 2'd1;
  localparam logic [1:0] StatusBadCheck = 2'd2;

  // One finished frame
  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  payload_length;
    logic [31:0] value_first;
    logic [31:0] value_second;
    logic [31:0] value_third;
  } xcfr_result_t;

endpackage

// File: rtl/xcfr_byte_if.sv
interface xcfr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// File: rtl/xcfr_result_if.sv
interface xcfr_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  payload_length;
  logic [31:0] value_first;
  logic [31:0] value_second;
  logic [31:0] value_third;

  modport source (
    output valid, output status, output payload_length,
    output value_first, output value_second, output value_third,
    input ready
  );
  modport sink (
    input valid, input status, input payload_length,
    input value_first, input value_second, input value_third,
    output ready
  );
endinterface

// File: rtl/xor_checked_frame_receiver_core.sv
// Channel   Dir  Contents
// rx_if     in   rx_byte: one received serial byte
// res_if    out  status, payload_length, value_first/second/third
// header    in   header_wr_en_i / header_wr_data_i: frame start byte
//
// One byte is taken every cycle, save a checksum byte held by a full output
// register; a result word appears in the cycle after its checksum byte and
// sits in that single output register. Only the checksum byte waits on it:
// other bytes are taken even while a result is stalled on res_if.
// Reset is asynchronous, active low; header byte returns to 0xAA.
module xor_checked_frame_receiver_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          header_wr_en_i,
  input  logic [7:0]    header_wr_data_i,
  xcfr_byte_if.sink     rx_if,
  xcfr_result_if.source res_if
);
  import xcfr_pkg::*;

  logic         at_check;
  logic         res_load;
  logic         out_space;
  logic         byte_fire;
  xcfr_result_t res_d;
  xcfr_result_t res_q;

  // checksum byte needs a free output slot
  assign rx_if.ready = !at_check || out_space;
  assign byte_fire   = rx_if.valid && rx_if.ready;

  xcfr_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .hdr_wr_en_i   (header_wr_en_i),
    .hdr_wr_data_i (header_wr_data_i),
    .byte_fire_i   (byte_fire),
    .byte_i        (rx_if.rx_byte),
    .at_check_o    (at_check),
    .res_load_o    (res_load),
    .res_o         (res_d)
  );

  xcfr_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (res_load),
    .data_i  (res_d),
    .space_o (out_space),
    .valid_o (res_if.valid),
    .ready_i (res_if.ready),
    .data_o  (res_q)
  );

  assign res_if.status         = res_q.status;
  assign res_if.payload_length = res_q.payload_length;
  assign res_if.value_first    = res_q.value_first;
  assign res_if.value_second   = res_q.value_second;
  assign res_if.value_third    = res_q.value_third;

  // Checks
  a_load_has_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> out_space)
    else $error("result loaded into a full output register");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |=> res_if.valid)
    else $error("loaded result not presented");

  a_values_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_if.valid && res_if.status == StatusValues) |-> (res_if.payload_length == 8'd12))
    else $error("value status without a twelve byte payload");

  a_values_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_if.valid && res_if.status != StatusValues) |->
      (res_if.value_first == '0 && res_if.value_second == '0 && res_if.value_third == '0))
    else $error("values not cleared for non-value status");

endmodule

// File: rtl/xcfr_parser.sv
module xcfr_parser (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  hdr_wr_en_i,
  input  logic [7:0]            hdr_wr_data_i,
  input  logic                  byte_fire_i,
  input  logic [7:0]            byte_i,
  output logic                  at_check_o,
  output logic                  res_load_o,
  output xcfr_pkg::xcfr_result_t res_o
);
  import xcfr_pkg::*;

  typedef enum logic [1:0] {
    PhHeader,
    PhLength,
    PhPayload,
    PhCheck
  } phase_e;

  phase_e              phase_q;
  logic [7:0]          header_q;
  logic [7:0]          exp_len_q;
  logic [CountW-1:0]   count_q;
  logic [7:0]          xor_q;
  logic [7:0]          store_q [StoreDepth];
  logic [CountW:0]     count_inc;
  logic                status_good;

  assign count_inc  = {1'b0, count_q} + {{CountW{1'b0}}, 1'b1};
  assign at_check_o = (phase_q == PhCheck);
  assign res_load_o = byte_fire_i && at_check_o;

  // Header byte register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= HeaderReset;
    end else if (hdr_wr_en_i) begin
      header_q <= hdr_wr_data_i;
    end
  end

  // Frame state machine
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhHeader;
      exp_len_q <= '0;
      count_q   <= '0;
      xor_q     <= '0;
    end else if (byte_fire_i) begin
      case (phase_q)
        PhHeader: begin
          if (byte_i == header_q) phase_q <= PhLength;
        end
        PhLength: begin
          exp_len_q <= byte_i;
          count_q   <= '0;
          xor_q     <= '0;
          phase_q   <= PhPayload;
        end
        PhPayload: begin
          xor_q   <= xor_q ^ byte_i;
          count_q <= count_inc[CountW-1:0];
          // zero length still takes one byte
          if (count_inc >= {1'b0, exp_len_q}) phase_q <= PhCheck;
        end
        PhCheck: begin
          phase_q <= PhHeader;
          count_q <= '0;
          xor_q   <= '0;
        end
        default: phase_q <= PhHeader;
      endcase
    end
  end

  // Payload store: first bytes only, no reset
  always_ff @(posedge clk_i) begin
    if (byte_fire_i && phase_q == PhPayload && count_q < CountW'(StoreDepth)) begin
      store_q[count_q[StoreIdxW-1:0]] <= byte_i;
    end
  end

  // Result word, formed on the checksum byte
  assign status_good = (byte_i == xor_q);

  always_comb begin
    res_o                = '0;
    res_o.payload_length = exp_len_q;
    if (!status_good) begin
      res_o.status = StatusBadCheck;
    end else if (exp_len_q == 8'(StoreDepth)) begin
      res_o.status       = StatusValues;
      res_o.value_first  = {store_q[0], store_q[1], store_q[2], store_q[3]};
      res_o.value_second = {store_q[4], store_q[5], store_q[6], store_q[7]};
      res_o.value_third  = {store_q[8], store_q[9], store_q[10], store_q[11]};
    end else begin
      res_o.status = StatusOtherLen;
    end
  end

endmodule

// File: rtl/xcfr_out_reg.sv
module xcfr_out_reg (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  xcfr_pkg::xcfr_result_t data_i,
  output logic                  space_o,
  output logic                  valid_o,
  input  logic                  ready_i,
  output xcfr_pkg::xcfr_result_t data_o
);
  import xcfr_pkg::*;

  logic         valid_q;
  xcfr_result_t data_q;

  // free when empty or draining this cycle
  assign space_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) data_q <= data_i;
  end

endmodule

// File: sim/xcfr_frame_checker.sv
`timescale 1ns / 1ps

// Watches both channels and the header write port, rebuilds each frame from
// the accepted bytes and compares every result word with the frame it closes.
module xcfr_frame_checker
  import xcfr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        header_wr_en_i,
  input  logic [7:0]  header_wr_data_i,
  xcfr_byte_if        rx_if,
  xcfr_result_if      res_if,
  output int unsigned mismatches_o,
  output int unsigned pending_o,
  output int unsigned frames_o,
  output int unsigned with_values_o,
  output int unsigned other_len_o,
  output int unsigned bad_check_o
);

  typedef enum logic [1:0] {
    HUNT_HEADER,
    TAKE_LENGTH,
    TAKE_PAYLOAD,
    TAKE_CHECKSUM
  } frame_phase_e;

  frame_phase_e phase_q;
  logic [7:0]   header_q;
  logic [7:0]   length_q;
  logic [7:0]   count_q;
  logic [7:0]   xor_q;
  logic [7:0]   payload_q [StoreDepth];

  xcfr_result_t frames_due [$];
  int unsigned  mismatches;
  int unsigned  frames;
  int unsigned  with_values;
  int unsigned  other_len;
  int unsigned  bad_check;

  // Advance the frame parser by one byte; a checksum byte queues a result.
  task automatic absorb_byte(input logic [7:0] b);
    xcfr_result_t frame;
    begin
      case (phase_q)
        HUNT_HEADER: begin
          if (b == header_q) phase_q = TAKE_LENGTH;
        end
        TAKE_LENGTH: begin
          length_q = b;
          count_q  = '0;
          xor_q    = '0;
          phase_q  = TAKE_PAYLOAD;
        end
        TAKE_PAYLOAD: begin
          if (count_q < StoreDepth) payload_q[count_q[StoreIdxW-1:0]] = b;
          xor_q   = xor_q ^ b;
          count_q = count_q + 8'd1;
          // zero length still takes one byte
          if (count_q >= length_q) phase_q = TAKE_CHECKSUM;
        end
        default: begin
          frame = '0;
          if (b != xor_q) frame.status = StatusBadCheck;
          else if (length_q == StoreDepth) frame.status = StatusValues;
          else frame.status = StatusOtherLen;
          frame.payload_length = length_q;
          // values only travel with a good 12-byte payload
          if (frame.status == StatusValues) begin
            frame.value_first  = {payload_q[0], payload_q[1], payload_q[2], payload_q[3]};
            frame.value_second = {payload_q[4], payload_q[5], payload_q[6], payload_q[7]};
            frame.value_third  = {payload_q[8], payload_q[9], payload_q[10], payload_q[11]};
          end
          frames_due.push_back(frame);
          phase_q = HUNT_HEADER;
          count_q = '0;
          xor_q   = '0;
        end
      endcase
    end
  endtask

  // Compare one result word against the oldest frame still due.
  task automatic check_result();
    xcfr_result_t seen;
    xcfr_result_t due;
    begin
      seen = '{status: res_if.status, payload_length: res_if.payload_length,
               value_first: res_if.value_first, value_second: res_if.value_second,
               value_third: res_if.value_third};
      if (frames_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] result word with no frame due: status %0d length %0d",
                   $realtime, seen.status, seen.payload_length);
      end else begin
        due = frames_due.pop_front();
        frames++;
        case (due.status)
          StatusValues:   with_values++;
          StatusOtherLen: other_len++;
          default:        bad_check++;
        endcase
        if (seen !== due) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("[%0t] frame %0d mismatch", $realtime, frames);
            $display("  status exp %0d got %0d, length exp %0d got %0d",
                     due.status, seen.status, due.payload_length, seen.payload_length);
            $display("  values exp %h %h %h", due.value_first, due.value_second,
                     due.value_third);
            $display("  values got %h %h %h", seen.value_first, seen.value_second,
                     seen.value_third);
          end
        end
      end
    end
  endtask

  // Results leave before new bytes enter: a frame closed at this edge
  // cannot be on the output yet.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  = HUNT_HEADER;
      header_q = HeaderReset;
      length_q = '0;
      count_q  = '0;
      xor_q    = '0;
      frames_due.delete();
    end else begin
      if (res_if.valid && res_if.ready) check_result();
      if (rx_if.valid && rx_if.ready) absorb_byte(rx_if.rx_byte);
      if (header_wr_en_i) header_q = header_wr_data_i;
    end
    mismatches_o  <= mismatches;
    pending_o     <= frames_due.size();
    frames_o      <= frames;
    with_values_o <= with_values;
    other_len_o   <= other_len;
    bad_check_o   <= bad_check;
  end

  initial begin
    mismatches  = 0;
    frames      = 0;
    with_values = 0;
    other_len   = 0;
    bad_check   = 0;
  end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps

// Stimulus and verdict; all checking lives in the frame checker.
module testbench;

  localparam int unsigned PhaseItems    = 160;
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned IdlePercent   = 32;

  logic        clk_i;
  logic        rst_ni;
  logic        header_wr_en_i;
  logic [7:0]  header_wr_data_i;

  xcfr_byte_if   rx_if ();
  xcfr_result_if res_if ();

  int unsigned mismatches;
  int unsigned pending;
  int unsigned frames;
  int unsigned with_values;
  int unsigned other_len;
  int unsigned bad_check;

  logic [7:0]  header_now;
  int unsigned sent_words;
  int unsigned settings;
  int unsigned long_left;
  bit          steady;
  bit          hold_off_req;

  xor_checked_frame_receiver_core u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .header_wr_en_i  (header_wr_en_i),
    .header_wr_data_i(header_wr_data_i),
    .rx_if           (rx_if),
    .res_if          (res_if)
  );

  xcfr_frame_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .header_wr_en_i  (header_wr_en_i),
    .header_wr_data_i(header_wr_data_i),
    .rx_if           (rx_if),
    .res_if          (res_if),
    .mismatches_o    (mismatches),
    .pending_o       (pending),
    .frames_o        (frames),
    .with_values_o   (with_values),
    .other_len_o     (other_len),
    .bad_check_o     (bad_check)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Result side: random stalls, a quiet stretch, and one long hold-off
  initial begin
    res_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        res_if.ready <= 1'b0;
        for (int n = 1; n < HoldOffCycles; n++) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else if (steady) begin
        res_if.ready <= 1'b1;
      end else begin
        res_if.ready <= ($urandom_range(0, 99) >= IdlePercent);
      end
    end
  end

  // Offer one byte, idling at random first; valid stays up after acceptance.
  task automatic send_word(input logic [7:0] b);
    while (!steady && $urandom_range(0, 99) < IdlePercent) begin
      rx_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk_i); while (!rx_if.ready);
    sent_words++;
  endtask

  // Header, length, payload, checksum; extreme fills alternate FF and 00.
  task automatic send_frame(input logic [7:0] len, input bit bad, input bit extreme);
    logic [7:0]  sum;
    logic [7:0]  b;
    int unsigned n;
    begin
      sum = '0;
      n   = (len == 0) ? 1 : len;
      send_word(header_now);
      send_word(len);
      for (int i = 0; i < n; i++) begin
        b   = extreme ? (i[0] ? 8'h00 : 8'hFF) : 8'($urandom_range(0, 255));
        sum = sum ^ b;
        send_word(b);
      end
      send_word(bad ? sum ^ 8'($urandom_range(1, 255)) : sum);
    end
  endtask

  // Byte that the parser drops while hunting for a header
  task automatic send_noise();
    logic [7:0] b;
    begin
      b = 8'($urandom_range(0, 255));
      if (b == header_now) b = ~b;
      send_word(b);
    end
  endtask

  // One random sequence: mostly well-formed frames, some noise and breakage.
  task automatic send_random_sequence();
    int unsigned pick;
    logic [7:0]  len;
    int unsigned cut;
    begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        send_frame(8'd12, $urandom_range(0, 9) == 0, 1'b0);
      end else if (pick < 65) begin
        send_frame(8'($urandom_range(0, 20)), 1'b0, 1'b0);
      end else if (pick < 75) begin
        send_frame(8'($urandom_range(0, 16)), 1'b1, 1'b0);
      end else if (pick < 82) begin
        send_frame(8'($urandom_range(13, 40)), $urandom_range(0, 1), 1'b0);
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 4)) send_noise();
      end else if (pick < 96 || long_left == 0) begin
        // truncated frame: the bytes sent next land inside its payload
        len = 8'($urandom_range(1, 12));
        cut = $urandom_range(0, len - 1);
        send_word(header_now);
        send_word(len);
        repeat (cut) send_word(8'($urandom_range(0, 255)));
      end else begin
        long_left--;
        send_frame((long_left == 0) ? 8'd255 : 8'($urandom_range(100, 255)),
                   $urandom_range(0, 1), 1'b0);
      end
    end
  endtask

  // Drop valid and let every due result drain before touching the header.
  task automatic drain();
    rx_if.valid <= 1'b0;
    repeat (4) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_header(input logic [7:0] value);
    header_wr_en_i   <= 1'b1;
    header_wr_data_i <= value;
    @(posedge clk_i);
    header_wr_en_i   <= 1'b0;
    header_now = value;
    settings++;
  endtask

  // Main stimulus
  initial begin
    logic [7:0] headers [5];
    int unsigned target;

    rx_if.valid      <= 1'b0;
    rx_if.rx_byte    <= '0;
    header_wr_en_i   <= 1'b0;
    header_wr_data_i <= '0;
    rst_ni            = 1'b0;
    header_now        = 8'hAA;
    sent_words        = 0;
    settings          = 1;
    long_left         = 3;
    steady            = 1'b0;
    hold_off_req      = 1'b0;
    headers = '{8'h00, 8'hFF, 8'($urandom_range(1, 254)), 8'h3C, 8'hAA};

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: dropped extremes, zero length, full-swing values, bad checksum
    send_word(8'h00);
    send_word(8'hFF);
    send_frame(8'd0, 1'b0, 1'b0);
    send_frame(8'd12, 1'b0, 1'b1);
    send_frame(8'd1, 1'b1, 1'b0);

    // Random phases under the reset header, then one per written header
    target = sent_words;
    for (int p = 0; p <= 5; p++) begin
      if (p > 0) begin
        drain();
        write_header(headers[p-1]);
      end
      steady = (p == 3);
      if (p == 2) hold_off_req = 1'b1;
      target += (p == 0) ? PhaseItems / 2 : PhaseItems;
      while (sent_words < target) send_random_sequence();
    end
    steady = 1'b0;

    drain();
    repeat (20) @(posedge clk_i);

    $display("Sent %0d bytes under %0d header settings, with one long result stall.",
             sent_words, settings);
    $display("Checked %0d frames: %0d with values, %0d other length, %0d bad checksum.",
             frames, with_values, other_len, bad_check);
    if (mismatches == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/xcfr_pkg.sv
rtl/xcfr_byte_if.sv
rtl/xcfr_result_if.sv
rtl/xcfr_parser.sv
rtl/xcfr_out_reg.sv
rtl/xor_checked_frame_receiver_core.sv
sim/xcfr_frame_checker.sv
sim/testbench.sv
